// ===== rtl/ogra_pkg.sv =====
// shared constants and request codes for the occupancy grid ray accumulator
package ogra_pkg;

	localparam int GRID_ROWS_DEF  = 256;
	localparam int GRID_COLS_DEF  = 256;
	localparam int COUNT_BITS_DEF = 16;

	localparam int COORD_W    = 12;
	localparam int SHOW_W     = 16;
	localparam int QUOT_BITS  = 7;
	localparam int PCT_SCALE  = 100;

	typedef enum logic [1:0] {
		REQ_RAY   = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

endpackage

// ===== rtl/occupancy_grid_ray_accumulator.sv =====
// Ray accumulator over a grid of pass and end counts kept in one on-chip memory.
// Requests come one at a time and in_stall stays high while a request is in work.
// An add ray request walks a Bresenham line: a setup step, then an address, read
// and write step per walked cell and for the end cell, for the read-modify-write
// of the single memory port. A read request steps through address, memory read,
// operand setup, seven restoring divide steps of one quotient bit each, and
// loading of the output register, where it waits while that register still holds
// an untaken result; it returns one word. A clear request, and also reset, start a
// clearing pass over all GRID_ROWS*GRID_COLS cells, one cell a cycle, 65536 cells
// at the default size. Request code 3 is taken and ignored.
module occupancy_grid_ray_accumulator #(
	parameter int GRID_ROWS  = ogra_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS  = ogra_pkg::GRID_COLS_DEF,
	parameter int COUNT_BITS = ogra_pkg::COUNT_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            req_type,
	input  logic signed [ogra_pkg::COORD_W-1:0]   start_x,
	input  logic signed [ogra_pkg::COORD_W-1:0]   start_y,
	input  logic signed [ogra_pkg::COORD_W-1:0]   end_x,
	input  logic signed [ogra_pkg::COORD_W-1:0]   end_y,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [ogra_pkg::QUOT_BITS-1:0]        occupancy_percent,
	output logic                                  cell_known,
	output logic [ogra_pkg::SHOW_W-1:0]           visit_total,
	output logic [ogra_pkg::SHOW_W-1:0]           hit_total
);

	localparam int CW        = ogra_pkg::COORD_W;
	localparam int CELLS     = GRID_ROWS * GRID_COLS;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int WORD_W    = 2 * COUNT_BITS;
	localparam int NUM_W     = COUNT_BITS + ogra_pkg::QUOT_BITS;
	localparam int DCNT_W    = $clog2(ogra_pkg::QUOT_BITS);
	localparam int ERR_W     = CW + 2;
	localparam int IDX_W     = CW + 2;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CLEAR = 9'b000000010,
		S_SETUP = 9'b000000100,
		S_ADDR  = 9'b000001000,
		S_RD    = 9'b000010000,
		S_WR    = 9'b000100000,
		S_NUM   = 9'b001000000,
		S_DIV   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic [ogra_pkg::SHOW_W-1:0] show16(input logic [COUNT_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
	endfunction

	state_t                  state_q;
	logic [ADDR_W-1:0]       clr_q;
	logic                    end_mode_q;
	logic                    is_read_q;
	logic signed [CW-1:0]    x_q, y_q, ex_q, ey_q;
	logic [CW-1:0]           major_q, minor_q, steps_q;
	logic                    steep_q, xdn_q, ydn_q;
	logic signed [ERR_W-1:0] err_q;
	logic [ADDR_W-1:0]       addr_q;
	logic                    ingrid_q;
	logic [WORD_W-1:0]       rdata_q;
	logic [COUNT_BITS-1:0]   hits_q, visits_q;
	logic                    known_q;
	logic [NUM_W-1:0]        rem_q, dsh_q;
	logic [DCNT_W-1:0]       dcnt_q;
	logic [ogra_pkg::QUOT_BITS-1:0] quot_q;
	logic                    out_valid_q;

	// pass count in the upper half of a word, end count in the lower half
	logic [WORD_W-1:0] mem [CELLS];

	logic in_acc, out_free;
	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// cell to slot
	logic signed [CW-1:0]    cx, cy;
	logic signed [IDX_W-1:0] row_s, col_s;
	logic                    cell_in;
	logic [ADDR_W-1:0]       cell_addr;
	always_comb begin
		cx = end_mode_q ? ex_q : x_q;
		cy = end_mode_q ? ey_q : y_q;
		row_s = {{2{cy[CW-1]}}, cy} + IDX_W'(GRID_ROWS / 2);
		col_s = {{2{cx[CW-1]}}, cx} + IDX_W'(GRID_COLS / 2);
		cell_in = !row_s[IDX_W-1] && !col_s[IDX_W-1]
			&& (row_s[IDX_W-2:0] < (IDX_W-1)'(GRID_ROWS))
			&& (col_s[IDX_W-2:0] < (IDX_W-1)'(GRID_COLS));
		cell_addr = ADDR_W'(ADDR_W'(row_s[IDX_W-2:0]) * ADDR_W'(GRID_COLS))
			+ ADDR_W'(col_s[IDX_W-2:0]);
	end

	// ray setup
	logic signed [CW:0] dx_d, dy_d;
	logic [CW-1:0]      adx, ady, maj_c, min_c;
	logic               steep_c;
	always_comb begin
		dx_d    = {ex_q[CW-1], ex_q} - {x_q[CW-1], x_q};
		dy_d    = {ey_q[CW-1], ey_q} - {y_q[CW-1], y_q};
		adx     = dx_d[CW] ? CW'(-dx_d) : CW'(dx_d);
		ady     = dy_d[CW] ? CW'(-dy_d) : CW'(dy_d);
		steep_c = ady > adx;
		maj_c   = steep_c ? ady : adx;
		min_c   = steep_c ? adx : ady;
	end

	// bresenham step
	logic                    err_ge;
	logic signed [ERR_W:0]   err_n;
	logic signed [CW-1:0]    xstep, ystep, x_n, y_n;
	always_comb begin
		err_ge = !err_q[ERR_W-1];
		err_n  = {err_q[ERR_W-1], err_q} + (ERR_W+1)'({minor_q, 1'b0});
		if (err_ge) begin
			err_n = err_n - (ERR_W+1)'({major_q, 1'b0});
		end
		xstep = xdn_q ? x_q - 1'b1 : x_q + 1'b1;
		ystep = ydn_q ? y_q - 1'b1 : y_q + 1'b1;
		if (steep_q) begin
			x_n = err_ge ? xstep : x_q;
			y_n = ystep;
		end else begin
			x_n = xstep;
			y_n = err_ge ? ystep : y_q;
		end
	end

	logic [COUNT_BITS-1:0] pass_f, end_f, hits_c, visits_c;
	logic [WORD_W-1:0]     wdata;
	logic                  we;
	logic [ADDR_W-1:0]     maddr;
	always_comb begin
		pass_f   = rdata_q[WORD_W-1:COUNT_BITS];
		end_f    = rdata_q[COUNT_BITS-1:0];
		hits_c   = ingrid_q ? end_f : '0;
		visits_c = ingrid_q ? pass_f : '0;
		we       = (state_q == S_CLEAR) || ((state_q == S_WR) && ingrid_q);
		maddr    = (state_q == S_CLEAR) ? clr_q : addr_q;
		if (state_q == S_CLEAR) begin
			wdata = '0;
		end else if (end_mode_q) begin
			wdata = {pass_f, sat_inc(end_f)};
		end else begin
			wdata = {sat_inc(pass_f), end_f};
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[maddr] <= wdata;
		end
		if (state_q == S_RD) begin
			rdata_q <= mem[maddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			end_mode_q  <= 1'b0;
			is_read_q   <= 1'b0;
			err_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new word may replace the one taken in the same cycle
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (req_type)
							ogra_pkg::REQ_RAY: begin
								end_mode_q <= 1'b0;
								is_read_q  <= 1'b0;
								state_q    <= S_SETUP;
							end
							ogra_pkg::REQ_READ: begin
								end_mode_q <= 1'b1;
								is_read_q  <= 1'b1;
								state_q    <= S_ADDR;
							end
							ogra_pkg::REQ_CLEAR: begin
								clr_q   <= '0;
								state_q <= S_CLEAR;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_SETUP: begin
					err_q      <= ERR_W'({min_c, 1'b0}) - ERR_W'(maj_c);
					end_mode_q <= (maj_c == '0);
					state_q    <= S_ADDR;
				end
				S_ADDR: begin
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= is_read_q ? S_NUM : S_WR;
				end
				S_WR: begin
					if (end_mode_q) begin
						state_q <= S_IDLE;
					end else begin
						err_q   <= ERR_W'(err_n);
						state_q <= S_ADDR;
						if (steps_q == CW'(1)) begin
							end_mode_q <= 1'b1;
						end
					end
				end
				S_NUM: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (dcnt_q == '0) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q  <= start_x;
				y_q  <= start_y;
				ex_q <= end_x;
				ey_q <= end_y;
			end
			S_SETUP: begin
				major_q <= maj_c;
				minor_q <= min_c;
				steps_q <= maj_c;
				steep_q <= steep_c;
				xdn_q   <= dx_d[CW] || (dx_d == '0);
				ydn_q   <= dy_d[CW] || (dy_d == '0);
			end
			S_ADDR: begin
				addr_q   <= cell_addr;
				ingrid_q <= cell_in;
			end
			S_WR: begin
				if (!end_mode_q) begin
					x_q     <= x_n;
					y_q     <= y_n;
					steps_q <= steps_q - 1'b1;
				end
			end
			S_NUM: begin
				hits_q   <= hits_c;
				visits_q <= visits_c;
				known_q  <= (hits_c != '0) || (visits_c != '0);
				rem_q    <= NUM_W'(NUM_W'(hits_c) * NUM_W'(ogra_pkg::PCT_SCALE));
				dsh_q    <= NUM_W'({1'b0, hits_c} + {1'b0, visits_c})
					<< (ogra_pkg::QUOT_BITS - 1);
				dcnt_q   <= DCNT_W'(ogra_pkg::QUOT_BITS - 1);
			end
			S_DIV: begin
				// one restoring step per cycle
				if (rem_q >= dsh_q) begin
					rem_q  <= rem_q - dsh_q;
					quot_q <= {quot_q[ogra_pkg::QUOT_BITS-2:0], 1'b1};
				end else begin
					quot_q <= {quot_q[ogra_pkg::QUOT_BITS-2:0], 1'b0};
				end
				dsh_q  <= dsh_q >> 1;
				dcnt_q <= dcnt_q - 1'b1;
			end
			S_OUT: begin
				if (out_free) begin
					occupancy_percent <= known_q ? quot_q : '0;
					cell_known        <= known_q;
					visit_total       <= show16(visits_q);
					hit_total         <= show16(hits_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/ogra_checker.sv =====
// port-level checks for the occupancy grid ray accumulator, with its bind
module ogra_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic [1:0]                          req_type,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [ogra_pkg::QUOT_BITS-1:0]      occupancy_percent,
	input logic                                cell_known,
	input logic [ogra_pkg::SHOW_W-1:0]         visit_total,
	input logic [ogra_pkg::SHOW_W-1:0]         hit_total
);

	// a waiting result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(occupancy_percent)
			&& $stable(cell_known) && $stable(visit_total) && $stable(hit_total))
		else $error("stalled result word changed");

	// an unknown cell reads as all zeros
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cell_known |-> occupancy_percent == '0
			&& visit_total == '0 && hit_total == '0)
		else $error("unknown cell with nonzero fields");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy_percent <= 7'd100)
		else $error("occupancy percent above 100");

	// hits with no visits give full occupancy
	a_pct_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cell_known && visit_total == '0 |-> occupancy_percent == 7'd100)
		else $error("hit-only cell not at 100 percent");

	// every real request keeps the block busy for at least the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (req_type == ogra_pkg::REQ_RAY
			|| req_type == ogra_pkg::REQ_READ || req_type == ogra_pkg::REQ_CLEAR)
			|=> in_stall)
		else $error("request taken without going busy");

endmodule

bind occupancy_grid_ray_accumulator ogra_checker u_ogra_checker (.*);

// ===== dv/occupancy_grid_ray_accumulator_test.sv =====
`timescale 1ns / 100ps
// testbench for the occupancy grid ray accumulator: directed request table, then random requests
module occupancy_grid_ray_accumulator_test;

	localparam int ROWS          = ogra_pkg::GRID_ROWS_DEF;
	localparam int COLS          = ogra_pkg::GRID_COLS_DEF;
	localparam int CELLS         = ROWS * COLS;
	localparam int COUNT_TOP     = (1 << ogra_pkg::COUNT_BITS_DEF) - 1;
	localparam int SHOW_TOP      = (1 << ogra_pkg::SHOW_W) - 1;
	localparam logic [1:0] REQ_IGNORED = 2'd3;
	localparam int RANDOM_ITEMS  = 1750;
	localparam int REPEAT_REPS   = 20;
	localparam int QUIET_LIMIT   = 4 * CELLS;

	typedef struct packed {
		logic [ogra_pkg::QUOT_BITS-1:0] pct;
		logic                           known;
		logic [ogra_pkg::SHOW_W-1:0]    visits;
		logic [ogra_pkg::SHOW_W-1:0]    hits;
	} cell_report_t;

	typedef struct {
		logic [1:0]   kind;
		int           sx;
		int           sy;
		int           ex;
		int           ey;
		int           reps;
		bit           fixed;
		cell_report_t want;
	} stim_row_t;

	localparam cell_report_t BLANK = '0;

	logic                                clk;
	logic                                arst_n;
	logic                                in_valid;
	logic                                in_stall;
	logic [1:0]                          req_type;
	logic signed [ogra_pkg::COORD_W-1:0] start_x;
	logic signed [ogra_pkg::COORD_W-1:0] start_y;
	logic signed [ogra_pkg::COORD_W-1:0] end_x;
	logic signed [ogra_pkg::COORD_W-1:0] end_y;
	logic                                out_valid;
	logic                                out_stall;
	logic [ogra_pkg::QUOT_BITS-1:0]      occupancy_percent;
	logic                                cell_known;
	logic [ogra_pkg::SHOW_W-1:0]         visit_total;
	logic [ogra_pkg::SHOW_W-1:0]         hit_total;

	int           pass_tally [CELLS];
	int           end_tally [CELLS];
	cell_report_t pending_reports [$];
	stim_row_t    directed_rows [$];
	int           mismatches;
	int           clears_left;
	bit           steady;

	occupancy_grid_ray_accumulator dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.req_type          (req_type),
		.start_x           (start_x),
		.start_y           (start_y),
		.end_x             (end_x),
		.end_y             (end_y),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.occupancy_percent (occupancy_percent),
		.cell_known        (cell_known),
		.visit_total       (visit_total),
		.hit_total         (hit_total)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit cell_index(int x, int y, output int idx);
		int row;
		int col;
		row = y + ROWS / 2;
		col = x + COLS / 2;
		idx = 0;
		if (row < 0 || row >= ROWS || col < 0 || col >= COLS)
			return 1'b0;
		idx = row * COLS + col;
		return 1'b1;
	endfunction

	function automatic void bump_tally(int x, int y, bit at_end);
		int idx;
		if (!cell_index(x, y, idx))
			return;
		if (at_end) begin
			if (end_tally[idx] < COUNT_TOP)
				end_tally[idx]++;
		end else if (pass_tally[idx] < COUNT_TOP) begin
			pass_tally[idx]++;
		end
	endfunction

	function automatic void trace_ray(int x1, int y1, int x2, int y2);
		int x;
		int y;
		int dx;
		int dy;
		int step_x;
		int step_y;
		int err;
		int swap;
		int i;
		bit steep;
		x = x1;
		y = y1;
		dx = (x2 > x1) ? x2 - x1 : x1 - x2;
		dy = (y2 > y1) ? y2 - y1 : y1 - y2;
		step_x = (x2 > x1) ? 1 : -1;
		step_y = (y2 > y1) ? 1 : -1;
		steep = 1'b0;
		if (dy > dx) begin
			swap = dx;
			dx = dy;
			dy = swap;
			steep = 1'b1;
		end
		err = 2 * dy - dx;
		// every walked cell short of the end gets a pass count
		for (i = 1; i <= dx; i++) begin
			bump_tally(x, y, 1'b0);
			if (err >= 0) begin
				if (steep)
					x += step_x;
				else
					y += step_y;
				err -= 2 * dx;
			end
			if (steep)
				y += step_y;
			else
				x += step_x;
			err += 2 * dy;
		end
		bump_tally(x2, y2, 1'b1);
	endfunction

	function automatic cell_report_t predict_read(int x, int y);
		cell_report_t r;
		int idx;
		int v;
		int h;
		r = BLANK;
		v = 0;
		h = 0;
		if (cell_index(x, y, idx)) begin
			v = pass_tally[idx];
			h = end_tally[idx];
		end
		if (v + h > 0) begin
			r.pct = ogra_pkg::QUOT_BITS'((ogra_pkg::PCT_SCALE * h) / (v + h));
			r.known = 1'b1;
		end
		r.visits = (v > SHOW_TOP) ? ogra_pkg::SHOW_W'(SHOW_TOP) : ogra_pkg::SHOW_W'(v);
		r.hits = (h > SHOW_TOP) ? ogra_pkg::SHOW_W'(SHOW_TOP) : ogra_pkg::SHOW_W'(h);
		return r;
	endfunction

	function automatic void wipe_tallies();
		foreach (pass_tally[i]) begin
			pass_tally[i] = 0;
			end_tally[i] = 0;
		end
	endfunction

	function automatic void queue_report(cell_report_t r);
		pending_reports = {pending_reports, r};
	endfunction

	function automatic void apply_request(stim_row_t r);
		case (r.kind)
			ogra_pkg::REQ_RAY: trace_ray(r.sx, r.sy, r.ex, r.ey);
			ogra_pkg::REQ_CLEAR: wipe_tallies();
			ogra_pkg::REQ_READ: begin
				if (r.fixed)
					queue_report(r.want);
				else
					queue_report(predict_read(r.ex, r.ey));
			end
			default: ;
		endcase
	endfunction

	function automatic cell_report_t reading(int pct, int known, int visits, int hits);
		cell_report_t r;
		r.pct = ogra_pkg::QUOT_BITS'(pct);
		r.known = known[0];
		r.visits = ogra_pkg::SHOW_W'(visits);
		r.hits = ogra_pkg::SHOW_W'(hits);
		return r;
	endfunction

	function automatic void add_row(logic [1:0] kind, int sx, int sy, int ex, int ey,
			int reps, bit fixed, cell_report_t want);
		stim_row_t r;
		r.kind = kind;
		r.sx = sx;
		r.sy = sy;
		r.ex = ex;
		r.ey = ey;
		r.reps = reps;
		r.fixed = fixed;
		r.want = want;
		directed_rows = {directed_rows, r};
	endfunction

	function automatic int near(int w);
		return int'($urandom_range(0, 2 * w)) - w;
	endfunction

	function automatic int full_coord();
		return int'($urandom_range(0, 4095)) - 2048;
	endfunction

	function automatic stim_row_t random_row();
		stim_row_t r;
		int pick;
		int reach;
		r.sx = full_coord();
		r.sy = full_coord();
		r.ex = full_coord();
		r.ey = full_coord();
		r.reps = 1;
		r.fixed = 1'b0;
		r.want = BLANK;
		pick = $urandom_range(0, 999);
		reach = $urandom_range(0, 99);
		if (pick < 3 && clears_left > 0) begin
			r.kind = ogra_pkg::REQ_CLEAR;
			clears_left--;
		end else if (pick < 30) begin
			r.kind = REQ_IGNORED;
		end else if (pick < 480) begin
			r.kind = ogra_pkg::REQ_RAY;
			// mostly short rays in a hot patch so reads find mixed counts
			if (reach < 85) begin
				r.sx = near(12);
				r.sy = near(12);
				r.ex = near(12);
				r.ey = near(12);
			end else if (reach < 99) begin
				r.sx = near(140);
				r.sy = near(140);
				r.ex = near(140);
				r.ey = near(140);
			end
		end else begin
			r.kind = ogra_pkg::REQ_READ;
			if (reach < 80) begin
				r.ex = near(14);
				r.ey = near(14);
			end else if (reach < 95) begin
				r.ex = near(140);
				r.ey = near(140);
			end
		end
		return r;
	endfunction

	// holds the word until taken, then updates the predicted grid
	task automatic send_word(stim_row_t r);
		while (!steady && $urandom_range(0, 99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.kind;
		start_x <= r.sx[ogra_pkg::COORD_W-1:0];
		start_y <= r.sy[ogra_pkg::COORD_W-1:0];
		end_x <= r.ex[ogra_pkg::COORD_W-1:0];
		end_y <= r.ey[ogra_pkg::COORD_W-1:0];
		do
			@(posedge clk);
		while (in_stall);
		apply_request(r);
	endtask

	task automatic issue_row(stim_row_t r);
		int n;
		for (n = 0; n < r.reps; n++)
			send_word(r);
	endtask

	task automatic check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_report(cell_report_t got);
		cell_report_t want;
		if (pending_reports.size() == 0) begin
			$display("%0t: unexpected word, expected none, actual %0d %0d %0d %0d",
				$time, got.pct, got.known, got.visits, got.hits);
			mismatches++;
			return;
		end
		want = pending_reports.pop_front();
		check_field("occupancy_percent", want.pct, got.pct);
		check_field("cell_known", want.known, got.known);
		check_field("visit_total", want.visits, got.visits);
		check_field("hit_total", want.hits, got.hits);
	endtask

	initial begin : receiver
		cell_report_t got;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				got.pct = occupancy_percent;
				got.known = cell_known;
				got.visits = visit_total;
				got.hits = hit_total;
				check_report(got);
			end
			out_stall <= !steady && ($urandom_range(0, 99) < 17);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = ogra_pkg::REQ_RAY;
		start_x = '0;
		start_y = '0;
		end_x = '0;
		end_y = '0;
		steady = 1'b0;
		mismatches = 0;
		clears_left = 1;
		wipe_tallies();

		add_row(ogra_pkg::REQ_READ, 0, 0, 0, 0, 1, 1'b1, BLANK);
		add_row(ogra_pkg::REQ_READ, 2047, 2047, -2048, -2048, 1, 1'b1, BLANK);
		add_row(ogra_pkg::REQ_READ, -2048, -2048, 2047, 2047, 1, 1'b1, BLANK);
		add_row(ogra_pkg::REQ_RAY, 5, 5, 5, 5, 1, 1'b0, BLANK);
		add_row(ogra_pkg::REQ_READ, 0, 0, 5, 5, 1, 1'b1, reading(100, 1, 0, 1));
		add_row(ogra_pkg::REQ_RAY, -3, -2, 4, 1, 1, 1'b0, BLANK);
		add_row(ogra_pkg::REQ_RAY, 2, -6, -1, 5, 1, 1'b0, BLANK);
		add_row(ogra_pkg::REQ_READ, 0, 0, 0, -1, 1, 1'b0, BLANK);
		add_row(ogra_pkg::REQ_READ, 0, 0, 1, -2, 1, 1'b0, BLANK);
		// rays that start far off the grid and cross it
		add_row(ogra_pkg::REQ_RAY, -2048, 0, 10, 0, 1, 1'b0, BLANK);
		add_row(ogra_pkg::REQ_RAY, -2048, -2048, 2047, 2047, 1, 1'b0, BLANK);
		add_row(ogra_pkg::REQ_RAY, 2047, -2048, -2048, 2047, 1, 1'b0, BLANK);
		add_row(ogra_pkg::REQ_READ, 0, 0, 10, 0, 1, 1'b0, BLANK);
		add_row(ogra_pkg::REQ_READ, 0, 0, -128, -128, 1, 1'b0, BLANK);
		add_row(ogra_pkg::REQ_READ, 0, 0, 127, -128, 1, 1'b0, BLANK);
		add_row(ogra_pkg::REQ_READ, 0, 0, 128, 0, 1, 1'b1, BLANK);
		add_row(REQ_IGNORED, -1, -1, -1, -1, 1, 1'b0, BLANK);
		add_row(ogra_pkg::REQ_READ, 0, 0, 5, 5, 1, 1'b0, BLANK);
		add_row(ogra_pkg::REQ_CLEAR, 0, 0, 0, 0, 1, 1'b0, BLANK);
		add_row(ogra_pkg::REQ_READ, 0, 0, 5, 5, 1, 1'b1, BLANK);
		// repeat a one-step ray so both cells build up counts
		add_row(ogra_pkg::REQ_RAY, 0, 0, 1, 0, REPEAT_REPS, 1'b0, BLANK);
		add_row(ogra_pkg::REQ_READ, 0, 0, 0, 0, 1, 1'b1, reading(0, 1, REPEAT_REPS, 0));
		add_row(ogra_pkg::REQ_READ, 0, 0, 1, 0, 1, 1'b1, reading(100, 1, 0, REPEAT_REPS));
		add_row(ogra_pkg::REQ_RAY, 1, 0, 1, 0, 1, 1'b0, BLANK);
		add_row(ogra_pkg::REQ_READ, 0, 0, 1, 0, 1, 1'b1,
			reading(100, 1, 0, REPEAT_REPS + 1));
		add_row(ogra_pkg::REQ_CLEAR, 0, 0, 0, 0, 1, 1'b0, BLANK);
		add_row(ogra_pkg::REQ_READ, 0, 0, 1, 0, 1, 1'b1, BLANK);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			issue_row(directed_rows[i]);

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			steady <= (n >= 700 && n < 1000);
			issue_row(random_row());
		end
		in_valid <= 1'b0;
		steady <= 1'b0;

		do
			@(posedge clk);
		while (in_stall || pending_reports.size() != 0);
		repeat (32) @(posedge clk);

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
